// ----- design/hsv2rgb_pkg.sv -----
package hsv2rgb_pkg;

    localparam int HUE_SECTOR = 960;
    localparam int HUE_BIAS_LO = 1792;
    localparam int RECIP15 = 4370;
    localparam int RECIP6 = 43;
    localparam int WGT_W = 10;
    localparam int DIV15_W = 12;
    localparam int BYTE_MAX = 255;

    typedef logic [WGT_W-1:0] t_weight;

    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } t_sector;

endpackage

// ----- design/hsv2rgb_sector.sv -----
module hsv2rgb_sector import hsv2rgb_pkg::*; #(
    parameter int FRAC_BITS = 12
) (
    input  logic                 i_clk,
    input  logic [1:0]           i_en,
    input  logic [15:0]          i_hue,
    input  logic [15:0]          i_saturation,
    input  logic [15:0]          i_brightness,
    output logic [FRAC_BITS:0]   o_sat,
    output logic [FRAC_BITS:0]   o_val,
    output t_weight              o_w_red,
    output t_weight              o_w_green,
    output t_weight              o_w_blue
);

    localparam int FW = FRAC_BITS + 1;
    localparam int ONE = 1 << FRAC_BITS;

    // stage 1: hue bias and coarse sector index, s/v clamp
    logic [16:0]   n_u;
    logic [23:0]   w_prod15;
    logic [6:0]    n_q;
    logic [FW-1:0] n_s, n_v;
    logic [16:0]   r_u;
    logic [6:0]    r_q;
    logic [FW-1:0] r_s1, r_v1;

    function automatic logic [FW-1:0] clamp_frac(input logic [15:0] x);
        logic [FW-1:0] res;
        if (x[15]) begin
            res = '0;
        end else if (int'($signed(x)) > ONE) begin
            res = FW'(ONE);
        end else begin
            res = FW'(x);
        end
        return res;
    endfunction

    always_comb begin
        n_u      = 17'({~i_hue[15], i_hue[14:0]}) + 17'(HUE_BIAS_LO);
        w_prod15 = 24'(n_u[16:6]) * 24'(RECIP15);
        n_q      = w_prod15[22:16];
        n_s      = clamp_frac(i_saturation);
        n_v      = clamp_frac(i_brightness);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_u  <= n_u;
            r_q  <= n_q;
            r_s1 <= n_s;
            r_v1 <= n_v;
        end
    end

    // stage 2: remainder in sector, sector mod 6, channel weights
    logic [16:0]   w_rem_full;
    t_weight       w_rem;
    logic [12:0]   w_prod6;
    logic [3:0]    w_k6;
    logic [6:0]    w_sec_full;
    t_sector       w_sec;
    t_weight       w_wx;
    t_weight       n_wr, n_wg, n_wb;
    t_weight       r_wr, r_wg, r_wb;
    logic [FW-1:0] r_s2, r_v2;

    always_comb begin
        w_rem_full = r_u - {r_q, 10'b0} + {4'b0, r_q, 6'b0};
        w_rem      = w_rem_full[WGT_W-1:0];
        w_prod6    = 13'(r_q) * 13'(RECIP6);
        w_k6       = w_prod6[11:8];
        w_sec_full = r_q - ({3'b0, w_k6} << 2) - ({3'b0, w_k6} << 1);
        w_sec      = t_sector'(w_sec_full[2:0]);
        w_wx       = w_sec_full[0] ? w_rem : WGT_W'(HUE_SECTOR) - w_rem;
    end

    always_comb begin
        n_wr = '0;
        n_wg = '0;
        n_wb = '0;
        unique case (w_sec)
            SEC_RED: begin
                n_wr = '0;
                n_wg = w_wx;
                n_wb = WGT_W'(HUE_SECTOR);
            end
            SEC_YELLOW: begin
                n_wr = w_wx;
                n_wg = '0;
                n_wb = WGT_W'(HUE_SECTOR);
            end
            SEC_GREEN: begin
                n_wr = WGT_W'(HUE_SECTOR);
                n_wg = '0;
                n_wb = w_wx;
            end
            SEC_CYAN: begin
                n_wr = WGT_W'(HUE_SECTOR);
                n_wg = w_wx;
                n_wb = '0;
            end
            SEC_BLUE: begin
                n_wr = w_wx;
                n_wg = WGT_W'(HUE_SECTOR);
                n_wb = '0;
            end
            SEC_MAGENTA: begin
                n_wr = '0;
                n_wg = WGT_W'(HUE_SECTOR);
                n_wb = w_wx;
            end
            default: begin
                n_wr = '0;
                n_wg = WGT_W'(HUE_SECTOR);
                n_wb = w_wx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_wr <= n_wr;
            r_wg <= n_wg;
            r_wb <= n_wb;
            r_s2 <= r_s1;
            r_v2 <= r_v1;
        end
    end

    assign o_sat     = r_s2;
    assign o_val     = r_v2;
    assign o_w_red   = r_wr;
    assign o_w_green = r_wg;
    assign o_w_blue  = r_wb;

endmodule

// ----- design/hsv2rgb_lane.sv -----
module hsv2rgb_lane import hsv2rgb_pkg::*; #(
    parameter int FRAC_BITS = 12
) (
    input  logic               i_clk,
    input  logic [3:0]         i_en,
    input  logic [FRAC_BITS:0] i_sat,
    input  logic [FRAC_BITS:0] i_val,
    input  t_weight            i_weight,
    output logic [7:0]         o_byte
);

    localparam int FW = FRAC_BITS + 1;
    localparam int YW = FRAC_BITS + WGT_W;
    localparam int AW = FW + YW;
    localparam int BW = AW + 8;
    localparam int SH = 2 * FRAC_BITS + 6;
    localparam logic [YW-1:0] Y_TOP = YW'(HUE_SECTOR) << FRAC_BITS;

    // y = ONE*960 - s*w, channel = floor(255 * v * y / (960 * ONE^2))
    logic [YW-1:0]      n_y, r_y;
    logic [FW-1:0]      r_v3;
    logic [AW-1:0]      n_a, r_a;
    logic [BW-1:0]      w_b;
    logic [DIV15_W-1:0] n_q, r_q;
    logic [24:0]        w_p;
    logic [8:0]         w_p_hi;
    logic [7:0]         n_byte, r_byte;

    always_comb begin
        n_y    = Y_TOP - YW'(i_sat) * YW'(i_weight);
        n_a    = AW'(r_v3) * AW'(r_y);
        w_b    = (BW'(r_a) << 8) - BW'(r_a);
        n_q    = DIV15_W'(w_b >> SH);
        w_p    = 25'(r_q) * 25'(RECIP15);
        w_p_hi = w_p[24:16];
        n_byte = (w_p_hi > 9'(BYTE_MAX)) ? 8'(BYTE_MAX) : w_p_hi[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_y  <= n_y;
            r_v3 <= i_val;
        end
        if (i_en[1]) begin
            r_a <= n_a;
        end
        if (i_en[2]) begin
            r_q <= n_q;
        end
        if (i_en[3]) begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// ----- design/hsv_to_rgb_converter.sv -----
// HSV to RGB converter, six register stages.
// Throughput: one transaction per cycle while i_stall is low; stages hold and refill independently.
// Reset: synchronous, active low i_rst_n clears all stage valid bits;
// datapath registers are not reset.
module hsv_to_rgb_converter import hsv2rgb_pkg::*; #(
    parameter int FRAC_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_hue,
    input  logic [15:0] i_saturation,
    input  logic [15:0] i_brightness,
    input  logic [7:0]  i_alpha_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha_out
);

    localparam int NSTG = 6;

    logic [NSTG-1:0]    r_vld;
    logic [NSTG-1:0]    w_en;
    logic [7:0]         r_alpha [NSTG];
    logic [FRAC_BITS:0] w_sat, w_val;
    t_weight            w_wr, w_wg, w_wb;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_alpha[0] <= i_alpha_in;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_en[k]) begin
                r_alpha[k] <= r_alpha[k-1];
            end
        end
    end

    hsv2rgb_sector #(
        .FRAC_BITS(FRAC_BITS)
    ) u_sector (
        .i_clk        (i_clk),
        .i_en         (w_en[1:0]),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_sat        (w_sat),
        .o_val        (w_val),
        .o_w_red      (w_wr),
        .o_w_green    (w_wg),
        .o_w_blue     (w_wb)
    );

    hsv2rgb_lane #(
        .FRAC_BITS(FRAC_BITS)
    ) u_lane_red (
        .i_clk    (i_clk),
        .i_en     (w_en[5:2]),
        .i_sat    (w_sat),
        .i_val    (w_val),
        .i_weight (w_wr),
        .o_byte   (o_red)
    );

    hsv2rgb_lane #(
        .FRAC_BITS(FRAC_BITS)
    ) u_lane_green (
        .i_clk    (i_clk),
        .i_en     (w_en[5:2]),
        .i_sat    (w_sat),
        .i_val    (w_val),
        .i_weight (w_wg),
        .o_byte   (o_green)
    );

    hsv2rgb_lane #(
        .FRAC_BITS(FRAC_BITS)
    ) u_lane_blue (
        .i_clk    (i_clk),
        .i_en     (w_en[5:2]),
        .i_sat    (w_sat),
        .i_val    (w_val),
        .i_weight (w_wb),
        .o_byte   (o_blue)
    );

    assign o_valid     = r_vld[NSTG-1];
    assign o_alpha_out = r_alpha[NSTG-1];

    a_empty_out_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output stage empty");

    a_drain_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |-> !o_stall)
        else $error("input stalled while output drains");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> &r_vld)
        else $error("input stalled with a bubble in the pipeline");

endmodule

// ----- test/tb_hsv_to_rgb_converter.sv -----
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter import hsv2rgb_pkg::*;;

    localparam int FRAC_BITS = 12;
    localparam int HUE_FULL = 6 * HUE_SECTOR;
    localparam int RANDOM_PIXELS = 1600;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [7:0] chan[4];
    } t_rgba;

    class rgb_scoreboard;
        t_rgba expected_q[$];
        int    accepted;
        int    compared;
        int    errors;
        int    sector_hits[6];
        int    clamp_hits;

        function longint unsigned clamp_unit(logic [15:0] raw);
            longint one;
            int     val;
            one = longint'(1) << FRAC_BITS;
            val = int'($signed(raw));
            if (val < 0 || longint'(val) > one) clamp_hits++;
            if (val < 0) return 0;
            if (longint'(val) > one) return one;
            return longint'(val);
        endfunction

        function logic [7:0] to_byte(longint unsigned num, longint unsigned den);
            longint unsigned b;
            b = (num * 255) / den;
            return (b > BYTE_MAX) ? 8'(BYTE_MAX) : b[7:0];
        endfunction

        function t_rgba convert(logic [15:0] hue, logic [15:0] sat,
                                logic [15:0] bri, logic [7:0] alpha);
            longint unsigned one, s, v, k, chroma, second, offset, den;
            longint unsigned r, g, b;
            int              h, t;
            t_sector         sec;
            t_rgba           res;
            one = longint'(1) << FRAC_BITS;
            h = int'($signed(hue)) % HUE_FULL;
            if (h < 0) h += HUE_FULL;
            s = clamp_unit(sat);
            v = clamp_unit(bri);
            t = h % (2 * HUE_SECTOR) - HUE_SECTOR;
            if (t < 0) t = -t;
            k = longint'(HUE_SECTOR - t);
            den = longint'(HUE_SECTOR) * one * one;
            chroma = v * s * longint'(HUE_SECTOR);
            second = v * s * k;
            offset = v * one * longint'(HUE_SECTOR) - chroma;
            sec = t_sector'(h / HUE_SECTOR);
            sector_hits[h / HUE_SECTOR]++;
            case (sec)
                SEC_RED: begin
                    r = chroma; g = second; b = 0;
                end
                SEC_YELLOW: begin
                    r = second; g = chroma; b = 0;
                end
                SEC_GREEN: begin
                    r = 0; g = chroma; b = second;
                end
                SEC_CYAN: begin
                    r = 0; g = second; b = chroma;
                end
                SEC_BLUE: begin
                    r = second; g = 0; b = chroma;
                end
                default: begin
                    r = chroma; g = 0; b = second;
                end
            endcase
            res.chan[0] = to_byte(r + offset, den);
            res.chan[1] = to_byte(g + offset, den);
            res.chan[2] = to_byte(b + offset, den);
            res.chan[3] = alpha;
            return res;
        endfunction

        function void note_pixel(logic [15:0] hue, logic [15:0] sat,
                                 logic [15:0] bri, logic [7:0] alpha);
            expected_q.push_back(convert(hue, sat, bri, alpha));
            accepted++;
        endfunction

        function void check_pixel(logic [7:0] red, logic [7:0] green,
                                  logic [7:0] blue, logic [7:0] alpha);
            string names[4];
            t_rgba exp_px;
            t_rgba act_px;
            names = '{"red", "green", "blue", "alpha"};
            act_px.chan = '{red, green, blue, alpha};
            compared++;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no transaction waiting: %0d %0d %0d %0d",
                         $time, red, green, blue, alpha);
                errors++;
                return;
            end
            exp_px = expected_q.pop_front();
            for (int i = 0; i < 4; i++) begin
                if (act_px.chan[i] !== exp_px.chan[i]) begin
                    $display("%0t: %s expected %0d actual %0d", $time, names[i],
                             exp_px.chan[i], act_px.chan[i]);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_hue;
    logic [15:0] i_saturation;
    logic [15:0] i_brightness;
    logic [7:0]  i_alpha_in;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha_out;

    rgb_scoreboard sb;
    logic          no_idle;
    int            cycles;

    hsv_to_rgb_converter #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_hue(i_hue),
        .i_saturation(i_saturation),
        .i_brightness(i_brightness),
        .i_alpha_in(i_alpha_in),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_red(o_red),
        .o_green(o_green),
        .o_blue(o_blue),
        .o_alpha_out(o_alpha_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending());
            $display("status: fail");
            $finish;
        end
    end

    // result side: random back-pressure unless no_idle is set, checks every accepted transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall)
            sb.check_pixel(o_red, o_green, o_blue, o_alpha_out);
        i_stall <= !no_idle && ($urandom_range(99) < 15);
    end

    task automatic send_pixel(input logic [15:0] hue, input logic [15:0] sat,
                              input logic [15:0] bri, input logic [7:0] alpha);
        while (!no_idle && $urandom_range(99) < 15) begin
            i_valid      <= 1'b0;
            i_hue        <= 16'($urandom());
            i_saturation <= 16'($urandom());
            i_brightness <= 16'($urandom());
            i_alpha_in   <= 8'($urandom());
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_brightness <= bri;
        i_alpha_in   <= alpha;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_pixel(hue, sat, bri, alpha);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_hue();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45) return 16'($urandom());
        if (sel < 85) return 16'($urandom_range(HUE_FULL - 1));
        return 16'($urandom_range(6) * HUE_SECTOR + $urandom_range(2) - 1);
    endfunction

    function automatic logic [15:0] rand_frac();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return 16'($urandom_range(1 << FRAC_BITS));
        if (sel < 80) return $urandom_range(1) ? 16'(1 << FRAC_BITS) : 16'd0;
        return 16'($urandom());
    endfunction

    initial begin
        sb = new();
        no_idle      <= 1'b0;
        cycles       <= 0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_stall      <= 1'b0;
        i_hue        <= '0;
        i_saturation <= '0;
        i_brightness <= '0;
        i_alpha_in   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sector starts, wrap edges, clamp edges
        send_pixel(16'd0,     16'd4096, 16'd4096, 8'hff);
        send_pixel(16'd960,   16'd4096, 16'd4096, 8'h00);
        send_pixel(16'd1920,  16'd4096, 16'd4096, 8'h55);
        send_pixel(16'd2880,  16'd4096, 16'd4096, 8'haa);
        send_pixel(16'd3840,  16'd4096, 16'd4096, 8'h01);
        send_pixel(16'd4800,  16'd4096, 16'd4096, 8'h80);
        send_pixel(16'd5759,  16'd4096, 16'd4096, 8'h7f);
        send_pixel(16'd5760,  16'd4096, 16'd4096, 8'hfe);
        send_pixel(16'hffff,  16'd4096, 16'd4096, 8'h10);
        send_pixel(-16'sd960, 16'd4096, 16'd4096, 8'h20);
        send_pixel(16'h8000,  16'd4096, 16'd4096, 8'h40);
        send_pixel(16'h7fff,  16'd4096, 16'd4096, 8'h04);
        send_pixel(16'd480,   16'h8000, 16'd4096, 8'h08);
        send_pixel(16'd480,   16'h7fff, 16'd4096, 8'h02);
        send_pixel(16'd1440,  16'd4097, 16'd2048, 8'h33);
        send_pixel(16'd2400,  16'd0,    16'd4096, 8'hcc);
        send_pixel(16'd3360,  16'd4095, 16'd4095, 8'h99);
        send_pixel(16'd4320,  16'd2048, 16'h8000, 8'h66);
        send_pixel(16'd5280,  16'd2048, 16'h7fff, 8'he7);
        send_pixel(16'd240,   16'd4096, 16'd0,    8'h18);
        send_pixel(16'd2000,  16'd3000, 16'd4097, 8'hc3);
        send_pixel(16'd959,   16'd1,    16'd1,    8'h3c);
        send_pixel(16'hffc0,  16'hffff, 16'hffff, 8'h5a);
        drain();

        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            no_idle <= (n >= 600 && n < 1000);
            if (n == 1200) drain();
            send_pixel(rand_hue(), rand_frac(), rand_frac(), 8'($urandom()));
        end
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d transactions sent, %0d results compared, %0d mismatches",
                 sb.accepted, sb.compared, sb.errors);
        $display("hue sector hits %0d/%0d/%0d/%0d/%0d/%0d, out-of-range fractions %0d",
                 sb.sector_hits[0], sb.sector_hits[1], sb.sector_hits[2],
                 sb.sector_hits[3], sb.sector_hits[4], sb.sector_hits[5],
                 sb.clamp_hits);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
